@@ sv/gpm_pkg.sv @@
// Shared types and constants of the glob pattern matcher.
// No dependencies; the cells, the parser, the top level and the testbench import this package.
package gpm_pkg;

  // Widths that cover the whole legal range of the capacity parameters.
  localparam int unsigned TOTAL_W = 7;
  localparam int unsigned SLOT_W  = 3;

  typedef enum logic [1:0] {
    ACT_PAT_BYTE  = 2'd0,
    ACT_PAT_END   = 2'd1,
    ACT_TEXT_BYTE = 2'd2,
    ACT_TEXT_END  = 2'd3
  } action_e;

  typedef enum logic [1:0] {
    ST_OK   = 2'd0,
    ST_BAD  = 2'd1,
    ST_OVER = 2'd2,
    ST_NONE = 2'd3
  } status_e;

  typedef enum logic [1:0] {
    KIND_STAR = 2'd0,
    KIND_ANY  = 2'd1,
    KIND_SET  = 2'd2
  } kind_e;

  localparam logic [7:0] CH_STAR   = 8'h2A;
  localparam logic [7:0] CH_QUEST  = 8'h3F;
  localparam logic [7:0] CH_LBRACK = 8'h5B;
  localparam logic [7:0] CH_RBRACK = 8'h5D;
  localparam logic [7:0] CH_BANG   = 8'h21;
  localparam logic [7:0] CH_CARET  = 8'h5E;
  localparam logic [7:0] CH_HYPHEN = 8'h2D;
  localparam logic [7:0] CH_BSLASH = 8'h5C;

  localparam logic [0:0] REP_PATTERN = 1'b0;
  localparam logic [0:0] REP_TEXT    = 1'b1;

  // Write command broadcast from the parser to the element cells.
  typedef struct packed {
    logic               clr_all;
    logic [TOTAL_W-1:0] idx;
    logic               init;
    kind_e              kind;
    logic               set_neg;
    logic [1:0]         add_we;
    logic [SLOT_W-1:0]  slot0;
    logic [SLOT_W-1:0]  slot1;
    logic [15:0]        range0;
    logic [15:0]        range1;
  } gpm_cmd_t;

  typedef struct packed {
    logic clr;
    logic step;
  } gpm_col_t;

  typedef struct packed {
    logic    valid;
    logic    kind;
    status_e status;
    logic    use_match;
  } gpm_res_t;

endpackage

@@ sv/gpm_if.sv @@
// Valid/ready channel interfaces for the input items and the reports.
// Depends on nothing but the wire types.
interface gpm_in_if;
  logic       valid;
  logic       ready;
  logic [1:0] action;
  logic [7:0] data_byte;
  modport source (output valid, action, data_byte, input ready);
  modport sink (input valid, action, data_byte, output ready);
endinterface

interface gpm_out_if;
  logic       valid;
  logic       ready;
  logic       report_kind;
  logic [1:0] status;
  logic       matched;
  modport source (output valid, report_kind, status, matched, input ready);
  modport sink (input valid, report_kind, status, matched, output ready);
endinterface

@@ sv/gpm_cell.sv @@
// One pattern element: its kind, byte ranges and prefix-match bit.
// Depends on gpm_pkg; cells chain left to right inside the top level.
module gpm_cell #(
  parameter int unsigned IDX        = 0,
  parameter int unsigned MAX_RANGES = 4,
  parameter int unsigned TW         = 6
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  gpm_pkg::gpm_cmd_t cmd_i,
  input  gpm_pkg::gpm_col_t col_i,
  input  logic [7:0]       byte_i,
  input  logic [TW-1:0]    total_i,
  input  logic             closed_left_i,
  input  logic             next_left_i,
  output logic             closed_o,
  output logic             next_o
);
  import gpm_pkg::*;

  localparam int unsigned RCW = $clog2(MAX_RANGES + 1);

  kind_e          kind_q, kind_d;
  logic           neg_q, neg_d;
  logic [RCW-1:0] rc_q, rc_d;
  logic           col_q, col_d;
  logic [15:0]    ranges_q [MAX_RANGES];

  logic active, hit, target, accepts;

  assign active = TW'(IDX) < total_i;
  assign target = cmd_i.idx == TOTAL_W'(IDX);

  always_comb begin
    kind_d = kind_q;
    neg_d  = neg_q;
    rc_d   = rc_q;
    if (cmd_i.clr_all) begin
      kind_d = KIND_STAR;
      neg_d  = 1'b0;
      rc_d   = '0;
    end
    if (target) begin
      if (cmd_i.init) begin
        kind_d = cmd_i.kind;
        neg_d  = 1'b0;
        rc_d   = '0;
      end
      if (cmd_i.set_neg) begin
        neg_d = 1'b1;
      end
      rc_d = rc_d + RCW'(cmd_i.add_we[0]) + RCW'(cmd_i.add_we[1]);
    end
  end

  always_comb begin
    hit = 1'b0;
    for (int k = 0; k < MAX_RANGES; k++) begin
      if (RCW'(k) < rc_q && byte_i >= ranges_q[k][7:0] && byte_i <= ranges_q[k][15:8]) begin
        hit = 1'b1;
      end
    end
    accepts = hit ^ neg_q;
  end

  // Star closure: the left neighbor of a star is never a star, so its
  // closed bit equals its stored bit and the chain stays two levels deep.
  assign closed_o = col_q | (active & (kind_q == KIND_STAR) & closed_left_i);

  always_comb begin
    next_o = 1'b0;
    if (active) begin
      unique case (kind_q)
        KIND_STAR: next_o = closed_o | next_left_i;
        KIND_ANY:  next_o = closed_left_i;
        KIND_SET:  next_o = closed_left_i & accepts;
        default:   next_o = 1'b0;
      endcase
    end
  end

  always_comb begin
    col_d = col_q;
    if (col_i.clr) begin
      col_d = 1'b0;
    end else if (col_i.step) begin
      col_d = next_o;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      kind_q <= KIND_STAR;
      neg_q  <= 1'b0;
      rc_q   <= '0;
      col_q  <= 1'b0;
    end else begin
      kind_q <= kind_d;
      neg_q  <= neg_d;
      rc_q   <= rc_d;
      col_q  <= col_d;
    end
  end

  always_ff @(posedge clk_i) begin
    for (int k = 0; k < MAX_RANGES; k++) begin
      if (target && cmd_i.add_we[0] && cmd_i.slot0 == SLOT_W'(k)) begin
        ranges_q[k] <= cmd_i.range0;
      end else if (target && cmd_i.add_we[1] && cmd_i.slot1 == SLOT_W'(k)) begin
        ranges_q[k] <= cmd_i.range1;
      end
    end
  end

endmodule

@@ sv/gpm_parser.sv @@
// Pattern compiler and action sequencer: one transaction per cycle in which acc_i is set.
// Depends on gpm_pkg; drives the element cells and the report.
module gpm_parser #(
  parameter int unsigned MAX_ELEMENTS = 32,
  parameter int unsigned MAX_RANGES   = 4,
  parameter int unsigned TW           = 6
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              acc_i,
  input  gpm_pkg::action_e  action_i,
  input  logic [7:0]        byte_i,
  output gpm_pkg::gpm_cmd_t cmd_o,
  output gpm_pkg::gpm_col_t col_o,
  output gpm_pkg::gpm_res_t res_o,
  output logic [TW-1:0]     total_o
);
  import gpm_pkg::*;

  localparam int unsigned RCW = $clog2(MAX_RANGES + 1);

  typedef enum logic [2:0] {
    M_NORMAL, M_ESC, M_OPEN, M_BODY, M_CLASS_ESC, M_RANGE_ESC, M_DEAD, M_LOADED
  } mode_e;

  localparam logic [2:0] HF_ATOM   = 3'b001;
  localparam logic [2:0] HF_HYPHEN = 3'b010;
  localparam logic [2:0] HF_LONE   = 3'b100;

  mode_e          mode_q, mode_d;
  logic [7:0]     ha_q, ha_d;
  logic [2:0]     hf_q, hf_d;
  logic [2:0]     cit_q, cit_d;
  status_e        st_q, st_d;
  logic [TW-1:0]  tot_q, tot_d;
  logic [RCW-1:0] rc_q, rc_d;
  logic           ls_q, ls_d;

  logic       req [2];
  logic [7:0] rlo [2];
  logic [7:0] rhi [2];
  logic       close, pend, ready, simple;
  kind_e      skind;

  assign ready   = (mode_q == M_LOADED) && (st_q == ST_OK);
  assign total_o = tot_q;

  always_comb begin
    mode_d = mode_q; ha_d = ha_q; hf_d = hf_q; cit_d = cit_q;
    st_d = st_q; tot_d = tot_q; rc_d = rc_q; ls_d = ls_q;
    cmd_o = '0;
    cmd_o.kind = KIND_STAR;
    col_o = '0;
    res_o = '0;
    res_o.status = ST_OK;
    req = '{1'b0, 1'b0};
    rlo = '{8'd0, 8'd0};
    rhi = '{8'd0, 8'd0};
    close = 1'b0; pend = 1'b0; simple = 1'b0;
    skind = KIND_STAR;

    if (acc_i) begin
      unique case (action_i)
        ACT_PAT_BYTE, ACT_PAT_END: begin
          if (mode_q == M_LOADED) begin
            tot_d = '0; ha_d = '0; hf_d = '0; cit_d = '0; mode_d = M_NORMAL;
            st_d = ST_OK; rc_d = '0; ls_d = 1'b0;
            cmd_o.clr_all = 1'b1;
            col_o.clr = 1'b1;
          end
          if (st_q == ST_NONE) begin
            st_d = ST_OK;
            col_o.clr = 1'b1;
          end
          cmd_o.idx = TOTAL_W'(tot_d);
          if (action_i == ACT_PAT_BYTE) begin
            unique case (mode_d)
              M_NORMAL: begin
                if (byte_i == CH_STAR) begin
                  simple = 1'b1; skind = KIND_STAR;
                end else if (byte_i == CH_QUEST) begin
                  simple = 1'b1; skind = KIND_ANY;
                end else if (byte_i == CH_LBRACK) begin
                  if (tot_d < TW'(MAX_ELEMENTS)) begin
                    cmd_o.init = 1'b1;
                    cmd_o.kind = KIND_SET;
                  end else if (st_d == ST_OK) begin
                    st_d = ST_OVER;
                  end
                  cit_d = '0; hf_d = '0; mode_d = M_OPEN; rc_d = '0;
                end else if (byte_i == CH_BSLASH) begin
                  mode_d = M_ESC;
                end else begin
                  simple = 1'b1; skind = KIND_SET;
                end
              end
              M_ESC: begin
                simple = 1'b1; skind = KIND_SET; mode_d = M_NORMAL;
              end
              M_OPEN, M_BODY: begin
                if (mode_d == M_OPEN && (byte_i == CH_BANG || byte_i == CH_CARET)) begin
                  mode_d = M_BODY;
                  cmd_o.set_neg = tot_d < TW'(MAX_ELEMENTS);
                end else begin
                  mode_d = M_BODY;
                  if ((hf_d & HF_LONE) != '0) begin
                    if (byte_i == CH_RBRACK) begin
                      req[0] = 1'b1; rlo[0] = CH_HYPHEN; rhi[0] = CH_HYPHEN; close = 1'b1;
                    end else begin
                      st_d = ST_BAD; mode_d = M_DEAD;
                    end
                  end else if ((hf_d & HF_HYPHEN) != '0) begin
                    if (byte_i == CH_RBRACK) begin
                      req[0] = 1'b1; rlo[0] = ha_d; rhi[0] = ha_d;
                      req[1] = 1'b1; rlo[1] = CH_HYPHEN; rhi[1] = CH_HYPHEN;
                      close = 1'b1;
                    end else if (byte_i == CH_BSLASH) begin
                      mode_d = M_RANGE_ESC;
                    end else if (byte_i == CH_HYPHEN) begin
                      st_d = ST_BAD; mode_d = M_DEAD;
                    end else if (ha_d > byte_i) begin
                      st_d = ST_BAD; mode_d = M_DEAD;
                    end else begin
                      req[0] = 1'b1; rlo[0] = ha_d; rhi[0] = byte_i; hf_d = '0;
                    end
                  end else if ((hf_d & HF_ATOM) != '0 && byte_i == CH_HYPHEN) begin
                    hf_d = hf_d | HF_HYPHEN;
                  end else begin
                    if ((hf_d & HF_ATOM) != '0) begin
                      req[0] = 1'b1; rlo[0] = ha_d; rhi[0] = ha_d; hf_d = '0; pend = 1'b1;
                    end
                    if (byte_i == CH_RBRACK) begin
                      if (cit_d == '0 && !pend) begin
                        st_d = ST_BAD; mode_d = M_DEAD;
                      end else begin
                        close = 1'b1;
                      end
                    end else if (byte_i == CH_HYPHEN) begin
                      if (cit_d == '0 && !pend) begin
                        req[1] = 1'b1; rlo[1] = CH_HYPHEN; rhi[1] = CH_HYPHEN;
                      end else begin
                        hf_d = HF_LONE;
                      end
                    end else if (byte_i == CH_BSLASH) begin
                      mode_d = M_CLASS_ESC;
                    end else begin
                      ha_d = byte_i; hf_d = HF_ATOM;
                    end
                  end
                end
              end
              M_CLASS_ESC: begin
                ha_d = byte_i; hf_d = HF_ATOM; mode_d = M_BODY;
              end
              M_RANGE_ESC: begin
                if (ha_d > byte_i) begin
                  st_d = ST_BAD; mode_d = M_DEAD;
                end else begin
                  req[0] = 1'b1; rlo[0] = ha_d; rhi[0] = byte_i; hf_d = '0; mode_d = M_BODY;
                end
              end
              default: ;
            endcase

            // A literal, an any byte or a star becomes an element of its own; a star right after a star folds into it.
            if (simple && !(skind == KIND_STAR && tot_d != '0 && ls_d)) begin
              if (tot_d >= TW'(MAX_ELEMENTS)) begin
                if (st_d == ST_OK) st_d = ST_OVER;
              end else begin
                cmd_o.init = 1'b1;
                cmd_o.kind = skind;
                if (skind == KIND_SET) begin
                  cmd_o.add_we[0] = 1'b1;
                  cmd_o.slot0 = '0;
                  cmd_o.range0 = {byte_i, byte_i};
                end
                tot_d = tot_d + 1'b1;
                ls_d = skind == KIND_STAR;
                rc_d = '0;
              end
            end

            for (int i = 0; i < 2; i++) begin
              if (req[i]) begin
                if (cit_d != 3'd7) cit_d = cit_d + 1'b1;
                if (tot_d < TW'(MAX_ELEMENTS)) begin
                  if (rc_d < RCW'(MAX_RANGES)) begin
                    cmd_o.add_we[i] = 1'b1;
                    if (i == 0) begin
                      cmd_o.slot0 = SLOT_W'(rc_d);
                      cmd_o.range0 = {rhi[i], rlo[i]};
                    end else begin
                      cmd_o.slot1 = SLOT_W'(rc_d);
                      cmd_o.range1 = {rhi[i], rlo[i]};
                    end
                    rc_d = rc_d + 1'b1;
                  end else if (st_d == ST_OK) begin
                    st_d = ST_OVER;
                  end
                end
              end
            end

            if (close) begin
              if (tot_d < TW'(MAX_ELEMENTS)) begin
                tot_d = tot_d + 1'b1;
                ls_d = 1'b0;
              end
              hf_d = '0; mode_d = M_NORMAL; rc_d = '0;
            end
          end else begin
            if (mode_d != M_NORMAL) st_d = ST_BAD;
            mode_d = M_LOADED;
            hf_d = '0;
            col_o.clr = 1'b1;
            res_o.valid = 1'b1;
            res_o.kind = REP_PATTERN;
            res_o.status = st_d;
          end
        end
        ACT_TEXT_BYTE: begin
          col_o.step = ready;
        end
        ACT_TEXT_END: begin
          res_o.valid = 1'b1;
          res_o.kind = REP_TEXT;
          res_o.use_match = ready;
          if (ready) begin
            res_o.status = ST_OK;
          end else begin
            res_o.status = (mode_q == M_LOADED) ? st_q : ST_NONE;
          end
          col_o.clr = 1'b1;
        end
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q <= M_NORMAL;
      ha_q   <= '0;
      hf_q   <= '0;
      cit_q  <= '0;
      st_q   <= ST_NONE;
      tot_q  <= '0;
      rc_q   <= '0;
      ls_q   <= 1'b0;
    end else begin
      mode_q <= mode_d;
      ha_q   <= ha_d;
      hf_q   <= hf_d;
      cit_q  <= cit_d;
      st_q   <= st_d;
      tot_q  <= tot_d;
      rc_q   <= rc_d;
      ls_q   <= ls_d;
    end
  end

  a_total_cap: assert property (@(posedge clk_i) disable iff (!rst_ni)
    tot_q <= TW'(MAX_ELEMENTS)) else $error("element count past capacity");
  a_rc_cap: assert property (@(posedge clk_i) disable iff (!rst_ni)
    rc_q <= RCW'(MAX_RANGES)) else $error("range count past capacity");
  a_dead_bad: assert property (@(posedge clk_i) disable iff (!rst_ni)
    mode_q == M_DEAD |-> st_q == ST_BAD) else $error("dead parser without fault status");

endmodule

@@ sv/glob_pattern_matcher.sv @@
// Glob pattern matcher: a valid/ready input channel carries actions (pattern
// byte, pattern end, text byte, text end) with a data byte; a valid/ready
// output channel carries reports (kind, status, matched).
// A pattern is sent byte by byte and closed by a pattern end, which returns a
// load report: ok, malformed, or over capacity. Text bytes are then streamed,
// and each text end returns a verdict report for the text since the last
// report. Text sent without a good pattern is ignored and its text end
// reports the load status, or "no pattern" when none has been loaded.
// An item is accepted in every cycle that the
// output register is empty or being drained, so text streams at one byte per
// cycle. A report appears in the cycle after its transaction. The rate is set by
// the column update through the row of element cells, which is at most two
// cells deep because adjacent stars fold into one.
// If the receiver stalls with a report held, input is held off until the
// report is taken. Reset clears the pattern store and returns the block to
// "no pattern".
module glob_pattern_matcher #(
  parameter int unsigned MAX_ELEMENTS = 32,
  parameter int unsigned MAX_RANGES   = 4
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  gpm_in_if.sink     in_i,
  gpm_out_if.source  out_o
);
  import gpm_pkg::*;

  localparam int unsigned TW = $clog2(MAX_ELEMENTS + 1);

  gpm_cmd_t      cmd;
  gpm_col_t      col;
  gpm_res_t      res;
  logic [TW-1:0] total;
  logic          acc;
  logic          col0_q;
  logic          closed [MAX_ELEMENTS+1];
  logic          nexts  [MAX_ELEMENTS+1];
  logic          match;

  logic       out_valid_q;
  logic       out_kind_q;
  logic [1:0] out_status_q;
  logic       out_matched_q;

  assign in_i.ready = !out_valid_q || out_o.ready;
  assign acc        = in_i.valid && in_i.ready;

  gpm_parser #(
    .MAX_ELEMENTS(MAX_ELEMENTS),
    .MAX_RANGES  (MAX_RANGES),
    .TW          (TW)
  ) u_parser (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .acc_i   (acc),
    .action_i(action_e'(in_i.action)),
    .byte_i  (in_i.data_byte),
    .cmd_o   (cmd),
    .col_o   (col),
    .res_o   (res),
    .total_o (total)
  );

  assign closed[0] = col0_q;
  assign nexts[0]  = 1'b0;

  for (genvar g = 0; g < MAX_ELEMENTS; g++) begin : g_cell
    gpm_cell #(
      .IDX       (g),
      .MAX_RANGES(MAX_RANGES),
      .TW        (TW)
    ) u_cell (
      .clk_i        (clk_i),
      .rst_ni       (rst_ni),
      .cmd_i        (cmd),
      .col_i        (col),
      .byte_i       (in_i.data_byte),
      .total_i      (total),
      .closed_left_i(closed[g]),
      .next_left_i  (nexts[g]),
      .closed_o     (closed[g+1]),
      .next_o       (nexts[g+1])
    );
  end

  always_comb begin
    match = 1'b0;
    for (int j = 0; j <= MAX_ELEMENTS; j++) begin
      if (TW'(j) == total) match = closed[j];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      col0_q      <= 1'b1;
      out_valid_q <= 1'b0;
    end else begin
      if (col.clr) begin
        col0_q <= 1'b1;
      end else if (col.step) begin
        col0_q <= 1'b0;
      end
      if (in_i.ready) begin
        out_valid_q <= res.valid;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_i.ready && res.valid) begin
      out_kind_q    <= res.kind;
      out_status_q  <= res.status;
      out_matched_q <= res.use_match & match;
    end
  end

  assign out_o.valid       = out_valid_q;
  assign out_o.report_kind = out_kind_q;
  assign out_o.status      = out_status_q;
  assign out_o.matched     = out_matched_q;

  a_report_source: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_q) |-> $past(acc && in_i.action[0]))
    else $error("report without an end transaction");
  a_match_ok: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q && out_matched_q |-> out_kind_q == REP_TEXT && out_status_q == ST_OK)
    else $error("match reported with a bad status");
  a_col_restart: assert property (@(posedge clk_i) disable iff (!rst_ni)
    acc && in_i.action == ACT_TEXT_END |=> col0_q)
    else $error("column not restarted after text end");

endmodule

@@ sim/testbench.sv @@
// Self-checking testbench of the glob pattern matcher: directed and random
// patterns and texts, checked against an in-bench predictor of the reports.
// Depends on gpm_pkg, gpm_if and glob_pattern_matcher.
module testbench;
  import gpm_pkg::*;

  localparam int NELEM = 32;
  localparam int NRANGE = 4;
  localparam int ITEM_GOAL = 1650;

  typedef enum {
    PM_NORMAL, PM_ESC, PM_OPEN, PM_BODY, PM_CLASS_ESC, PM_RANGE_ESC, PM_DEAD, PM_LOADED
  } parse_mode_e;

  localparam bit [2:0] HOLD_ATOM = 3'd1;
  localparam bit [2:0] HOLD_HYPHEN = 3'd2;
  localparam bit [2:0] HOLD_LONE = 3'd4;

  typedef struct {
    bit      kind;
    status_e status;
    bit      matched;
  } report_t;

  class glob_report_book;
    kind_e       elem_kind[NELEM];
    bit          elem_neg[NELEM];
    int          elem_ranges[NELEM];
    bit [15:0]   bounds[NELEM*NRANGE];
    int          total;
    bit [NELEM:0] column;
    parse_mode_e mode;
    bit [7:0]    atom;
    bit [2:0]    held;
    int          citems;
    status_e     pstat;
    report_t     expected_reports[$];
    int          errors, reports_seen, matches_seen, loads_bad, loads_over;

    function new();
      clear_store();
      pstat = ST_NONE;
    endfunction

    function void clear_column();
      column = '0;
      column[0] = 1'b1;
    endfunction

    function void clear_store();
      for (int i = 0; i < NELEM; i++) begin
        elem_kind[i] = KIND_STAR;
        elem_neg[i] = 0;
        elem_ranges[i] = 0;
      end
      total = 0;
      atom = 0;
      held = 0;
      citems = 0;
      mode = PM_NORMAL;
      pstat = ST_OK;
      clear_column();
    endfunction

    function void flag_over();
      if (pstat == ST_OK) pstat = ST_OVER;
    endfunction

    function void flag_bad();
      pstat = ST_BAD;
      mode = PM_DEAD;
    endfunction

    function void add_simple(kind_e k, bit [7:0] lit);
      if (k == KIND_STAR && total > 0 && total <= NELEM && elem_kind[total-1] == KIND_STAR)
        return;
      if (total >= NELEM) begin
        flag_over();
        return;
      end
      elem_kind[total] = k;
      elem_neg[total] = 0;
      elem_ranges[total] = 0;
      if (k == KIND_SET) begin
        bounds[total*NRANGE] = {lit, lit};
        elem_ranges[total] = 1;
      end
      total++;
    endfunction

    function void class_add(bit [7:0] lo, bit [7:0] hi);
      if (citems < 7) citems++;
      if (total >= NELEM) return;
      if (elem_ranges[total] < NRANGE) begin
        bounds[total*NRANGE + elem_ranges[total]] = {hi, lo};
        elem_ranges[total]++;
      end else begin
        flag_over();
      end
    endfunction

    function void class_close();
      if (total < NELEM) total++;
      held = 0;
      mode = PM_NORMAL;
    endfunction

    function void range_end(bit [7:0] last);
      if (atom > last) begin
        flag_bad();
        return;
      end
      class_add(atom, last);
      held = 0;
      mode = PM_BODY;
    endfunction

    function void class_byte(bit [7:0] ch);
      if (held & HOLD_LONE) begin
        if (ch == CH_RBRACK) begin
          class_add(CH_HYPHEN, CH_HYPHEN);
          class_close();
        end else begin
          flag_bad();
        end
        return;
      end
      if (held & HOLD_HYPHEN) begin
        if (ch == CH_RBRACK) begin
          class_add(atom, atom);
          class_add(CH_HYPHEN, CH_HYPHEN);
          class_close();
        end else if (ch == CH_BSLASH) begin
          mode = PM_RANGE_ESC;
        end else if (ch == CH_HYPHEN) begin
          flag_bad();
        end else begin
          range_end(ch);
        end
        return;
      end
      if (held & HOLD_ATOM) begin
        if (ch == CH_HYPHEN) begin
          held |= HOLD_HYPHEN;
          return;
        end
        class_add(atom, atom);
        held = 0;
      end
      if (ch == CH_RBRACK) begin
        if (citems == 0) flag_bad();
        else class_close();
      end else if (ch == CH_HYPHEN) begin
        if (citems == 0) class_add(CH_HYPHEN, CH_HYPHEN);
        else held = HOLD_LONE;
      end else if (ch == CH_BSLASH) begin
        mode = PM_CLASS_ESC;
      end else begin
        atom = ch;
        held = HOLD_ATOM;
      end
    endfunction

    function void pattern_byte(bit [7:0] ch);
      case (mode)
        PM_NORMAL: begin
          if (ch == CH_STAR) add_simple(KIND_STAR, 0);
          else if (ch == CH_QUEST) add_simple(KIND_ANY, 0);
          else if (ch == CH_LBRACK) begin
            if (total < NELEM) begin
              elem_kind[total] = KIND_SET;
              elem_neg[total] = 0;
              elem_ranges[total] = 0;
            end else begin
              flag_over();
            end
            citems = 0;
            held = 0;
            mode = PM_OPEN;
          end else if (ch == CH_BSLASH) mode = PM_ESC;
          else add_simple(KIND_SET, ch);
        end
        PM_ESC: begin
          add_simple(KIND_SET, ch);
          mode = PM_NORMAL;
        end
        PM_OPEN: begin
          mode = PM_BODY;
          if (ch == CH_BANG || ch == CH_CARET) begin
            if (total < NELEM) elem_neg[total] = 1;
          end else begin
            class_byte(ch);
          end
        end
        PM_BODY: class_byte(ch);
        PM_CLASS_ESC: begin
          atom = ch;
          held = HOLD_ATOM;
          mode = PM_BODY;
        end
        PM_RANGE_ESC: range_end(ch);
        default: ;
      endcase
    endfunction

    function bit accepts(int e, bit [7:0] b);
      bit hit;
      bit [15:0] r;
      hit = 0;
      for (int k = 0; k < elem_ranges[e] && k < NRANGE; k++) begin
        r = bounds[e*NRANGE + k];
        if (b >= r[7:0] && b <= r[15:8]) hit = 1;
      end
      return elem_neg[e] ? !hit : hit;
    endfunction

    function void close_stars();
      for (int j = 1; j <= total && j <= NELEM; j++)
        if (elem_kind[j-1] == KIND_STAR && column[j-1]) column[j] = 1'b1;
    endfunction

    function void text_byte(bit [7:0] b);
      bit [NELEM:0] nxt;
      close_stars();
      nxt = '0;
      for (int j = 1; j <= total && j <= NELEM; j++) begin
        if (elem_kind[j-1] == KIND_STAR) nxt[j] = column[j] | nxt[j-1];
        else if (elem_kind[j-1] == KIND_ANY) nxt[j] = column[j-1];
        else nxt[j] = column[j-1] & accepts(j-1, b);
      end
      column = nxt;
    endfunction

    // Notes one accepted input transaction and queues the report it causes.
    function void take_item(action_e act, bit [7:0] b);
      report_t rep;
      bit loaded_ok;
      loaded_ok = (mode == PM_LOADED) && (pstat == ST_OK);
      if (act == ACT_PAT_BYTE || act == ACT_PAT_END) begin
        if (mode == PM_LOADED) clear_store();
        if (pstat == ST_NONE) begin
          pstat = ST_OK;
          clear_column();
        end
        if (act == ACT_PAT_BYTE) begin
          pattern_byte(b);
          return;
        end
        if (mode != PM_NORMAL) pstat = ST_BAD;
        mode = PM_LOADED;
        held = 0;
        clear_column();
        if (pstat == ST_BAD) loads_bad++;
        if (pstat == ST_OVER) loads_over++;
        rep = '{REP_PATTERN, pstat, 1'b0};
        expected_reports.push_back(rep);
        return;
      end
      if (act == ACT_TEXT_BYTE) begin
        if (loaded_ok) text_byte(b);
        return;
      end
      rep.kind = REP_TEXT;
      rep.matched = 0;
      if (loaded_ok) begin
        close_stars();
        rep.status = ST_OK;
        rep.matched = (total <= NELEM) && column[total];
        if (rep.matched) matches_seen++;
      end else begin
        rep.status = (mode == PM_LOADED) ? pstat : ST_NONE;
      end
      clear_column();
      expected_reports.push_back(rep);
    endfunction

    function void check_report(bit kind, bit [1:0] st, bit m);
      report_t exp_rep;
      reports_seen++;
      if (expected_reports.size() == 0) begin
        $display("%0t: unexpected report kind=%0d status=%0d matched=%0d",
                 $time, kind, st, m);
        errors++;
        return;
      end
      exp_rep = expected_reports.pop_front();
      if (kind !== exp_rep.kind) begin
        $display("%0t: report_kind expected %0d actual %0d", $time, exp_rep.kind, kind);
        errors++;
      end
      if (st !== exp_rep.status) begin
        $display("%0t: status expected %0d actual %0d", $time, exp_rep.status, st);
        errors++;
      end
      if (m !== exp_rep.matched) begin
        $display("%0t: matched expected %0d actual %0d", $time, exp_rep.matched, m);
        errors++;
      end
    endfunction
  endclass

  logic clk_i = 0;
  logic rst_ni = 0;
  gpm_in_if in_ch();
  gpm_out_if out_ch();

  glob_pattern_matcher uut (.clk_i(clk_i), .rst_ni(rst_ni), .in_i(in_ch), .out_o(out_ch));

  glob_report_book book = new();
  int items_sent;
  int stall_left;
  bit no_idle;

  always #5 clk_i = ~clk_i;

  initial begin
    in_ch.valid = 0;
    in_ch.action = ACT_TEXT_END;
    in_ch.data_byte = 0;
    out_ch.ready = 0;
  end

  initial begin
    #2000000;
    $display("Testbench completed WITH ERRORS");
    $finish;
  end

  // Receiver: random stalls, a quiet stretch, and long hold-offs on request.
  always @(negedge clk_i) begin
    if (stall_left > 0) begin
      out_ch.ready <= 1'b0;
      stall_left <= stall_left - 1;
    end else begin
      out_ch.ready <= no_idle || ($urandom_range(0, 99) >= 16);
    end
  end

  always @(posedge clk_i)
    if (rst_ni && out_ch.valid && out_ch.ready)
      book.check_report(out_ch.report_kind, out_ch.status, out_ch.matched);

  // Called at a falling edge; returns at the falling edge after acceptance.
  task automatic send_item(action_e act, bit [7:0] b);
    if (!no_idle && $urandom_range(0, 99) < 16) begin
      in_ch.valid = 0;
      @(negedge clk_i);
    end
    in_ch.valid = 1;
    in_ch.action = act;
    in_ch.data_byte = b;
    @(posedge clk_i);
    while (!in_ch.ready) @(posedge clk_i);
    book.take_item(act, b);
    items_sent++;
    @(negedge clk_i);
  endtask

  task automatic send_pattern(string s);
    for (int i = 0; i < s.len(); i++) send_item(ACT_PAT_BYTE, s[i]);
    send_item(ACT_PAT_END, 8'($urandom_range(0, 255)));
  endtask

  task automatic send_text(string s);
    for (int i = 0; i < s.len(); i++) send_item(ACT_TEXT_BYTE, s[i]);
    send_item(ACT_TEXT_END, 8'($urandom_range(0, 255)));
  endtask

  function automatic bit [7:0] text_char();
    return ($urandom_range(0, 9) == 0) ? 8'($urandom_range(0, 255))
                                       : 8'($urandom_range(8'h61, 8'h64));
  endfunction

  function automatic bit [7:0] class_atom();
    case ($urandom_range(0, 5))
      0: return 8'($urandom_range(0, 255));
      1: return CH_HYPHEN;
      default: return 8'($urandom_range(8'h61, 8'h64));
    endcase
  endfunction

  // Builds a random pattern: mostly well-formed, sometimes long or broken.
  task automatic random_pattern();
    int n;
    int items;
    bit [7:0] lo;
    n = ($urandom_range(0, 15) == 0) ? $urandom_range(28, 36) : $urandom_range(0, 6);
    for (int e = 0; e < n; e++) begin
      case ($urandom_range(0, 9))
        0, 1: send_item(ACT_PAT_BYTE, CH_STAR);
        2: send_item(ACT_PAT_BYTE, CH_QUEST);
        3: begin
          send_item(ACT_PAT_BYTE, CH_BSLASH);
          send_item(ACT_PAT_BYTE, 8'($urandom_range(0, 255)));
        end
        4, 5: begin
          send_item(ACT_PAT_BYTE, CH_LBRACK);
          if ($urandom_range(0, 2) == 0)
            send_item(ACT_PAT_BYTE, $urandom_range(0, 1) ? CH_BANG : CH_CARET);
          items = $urandom_range(1, 6);
          for (int k = 0; k < items; k++) begin
            lo = class_atom();
            if ($urandom_range(0, 4) == 0) send_item(ACT_PAT_BYTE, CH_BSLASH);
            send_item(ACT_PAT_BYTE, lo);
            if ($urandom_range(0, 2) == 0) begin
              send_item(ACT_PAT_BYTE, CH_HYPHEN);
              send_item(ACT_PAT_BYTE, $urandom_range(0, 7) == 0 ? 8'($urandom_range(0, 255))
                                      : 8'(lo + $urandom_range(0, 3)));
            end
          end
          if ($urandom_range(0, 19) != 0) send_item(ACT_PAT_BYTE, CH_RBRACK);
        end
        6: begin
          // Stray special bytes make a share of the patterns malformed.
          case ($urandom_range(0, 3))
            0: send_item(ACT_PAT_BYTE, CH_RBRACK);
            1: send_item(ACT_PAT_BYTE, CH_HYPHEN);
            2: send_item(ACT_PAT_BYTE, CH_LBRACK);
            default: send_item(ACT_PAT_BYTE, 8'($urandom_range(0, 255)));
          endcase
        end
        default: send_item(ACT_PAT_BYTE, 8'($urandom_range(8'h61, 8'h64)));
      endcase
    end
    if ($urandom_range(0, 29) == 0) send_item(ACT_PAT_BYTE, CH_BSLASH);
    send_item(ACT_PAT_END, 8'($urandom_range(0, 255)));
  endtask

  initial begin
    int texts, len;
    bit pressed, paused;
    repeat (4) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1;
    @(negedge clk_i);

    // Directed cases: no pattern yet, empty pattern, classes, escapes, faults.
    send_item(ACT_TEXT_BYTE, 8'h61);
    send_item(ACT_TEXT_END, 8'h00);
    send_pattern("");
    send_text("");
    send_text("a");
    send_pattern("a*b?");
    send_text("axxbz");
    send_pattern("[!a-c]");
    send_text("d");
    send_pattern("[]");
    send_text("a");
    send_pattern("[-a-]");
    send_text("-");
    send_pattern("[b-a]");
    send_pattern("[a");
    send_pattern("\\");
    send_pattern("[^\\]]");
    send_text("x");
    send_pattern("[abcde]");
    send_text("a");
    send_item(ACT_PAT_BYTE, 8'h00);
    send_item(ACT_PAT_BYTE, 8'hFF);
    send_item(ACT_PAT_END, 8'hFF);
    send_item(ACT_TEXT_BYTE, 8'h00);
    send_item(ACT_TEXT_BYTE, 8'hFF);
    send_item(ACT_TEXT_END, 8'h00);
    send_pattern("*********************************x");
    send_text("yyx");

    while (items_sent < ITEM_GOAL) begin
      no_idle = (items_sent > 700 && items_sent < 900);
      if (!pressed && items_sent > 400) begin
        pressed = 1;
        stall_left = 300;
      end
      if (!paused && items_sent > 1100) begin
        paused = 1;
        in_ch.valid = 0;
        while (book.expected_reports.size() != 0) @(negedge clk_i);
      end
      if ($urandom_range(0, 19) == 0) begin
        // Text on the pattern already loaded, or a pattern end with nothing before it.
        if ($urandom_range(0, 1)) send_item(ACT_PAT_END, 8'($urandom_range(0, 255)));
        send_text("ab");
      end else begin
        random_pattern();
      end
      texts = $urandom_range(1, 4);
      for (int t = 0; t < texts; t++) begin
        len = $urandom_range(0, 10);
        for (int i = 0; i < len; i++) send_item(ACT_TEXT_BYTE, text_char());
        send_item(ACT_TEXT_END, 8'($urandom_range(0, 255)));
      end
    end
    in_ch.valid = 0;
    no_idle = 0;

    while (book.expected_reports.size() != 0) @(negedge clk_i);
    repeat (20) @(negedge clk_i);
    $display("Sent %0d transactions; checked %0d reports, %0d matches.",
             items_sent, book.reports_seen, book.matches_seen);
    $display("Loads malformed: %0d, over capacity: %0d.", book.loads_bad, book.loads_over);
    if (book.errors == 0 && book.expected_reports.size() == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end
endmodule
